// File: hdl/ltr_pkg.sv
// ltr_pkg: shared types and constants for the led twinkle ramp generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ltr_pkg;

    localparam int DEFAULT_CHANNELS = 4;

    localparam int LEVEL_W = 16;
    localparam int BRIGHT_W = 8;
    localparam int CHAN_W = 2;
    localparam int PROD_W = LEVEL_W + BRIGHT_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic                rising;
        logic [LEVEL_W-1:0]  step;
        logic [BRIGHT_W-1:0] top;
        logic [BRIGHT_W-1:0] bottom;
    } ramp_entry_t;

    typedef struct packed {
        logic [PROD_W-1:0]   prod;
        logic                neg;
        logic [BRIGHT_W-1:0] bottom;
        logic [BRIGHT_W-1:0] floor_level;
        logic [CHAN_W-1:0]   channel;
    } map_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [BRIGHT_W-1:0] duty;
    } out_beat_t;

endpackage

// File: hdl/ltr_duty_map.sv
// ltr_duty_map: maps a registered level-span product to a duty and applies the floor
// depends on ltr_pkg
`timescale 1ns / 1ps

module ltr_duty_map (
    input  ltr_pkg::map_req_t  req,
    output ltr_pkg::out_beat_t beat
);
    import ltr_pkg::*;

    logic [PROD_W:0]     quot_sum;
    logic [BRIGHT_W-1:0] quot;
    logic [BRIGHT_W-1:0] mapped;

    // divide by 65535: exact for products below 65535 * 256
    always_comb begin
        quot_sum = {1'b0, req.prod} + (PROD_W+1)'(req.prod >> LEVEL_W) + (PROD_W+1)'(1);
        quot     = quot_sum[PROD_W-1:LEVEL_W];
        mapped   = req.neg ? (req.bottom - quot) : (req.bottom + quot);
        beat.channel = req.channel;
        beat.duty    = (mapped < req.floor_level) ? req.floor_level : mapped;
    end

endmodule

// File: hdl/ltr_out_fifo.sv
// ltr_out_fifo: small result queue between the ramp pipeline and the m_ channel
// depends on ltr_pkg
`timescale 1ns / 1ps

module ltr_out_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  ltr_pkg::out_beat_t          push_beat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ltr_pkg::out_beat_t          head_beat,
    output logic [ltr_pkg::FIFO_CNT_W-1:0] count
);
    import ltr_pkg::*;

    out_beat_t             store [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    always_comb begin
        pop         = m_valid && m_ready;
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_beat;
        end
    end

    assign m_valid   = (count_reg != '0);
    assign head_beat = store[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: hdl/led_twinkle_ramp_generator_unit.sv
// led_twinkle_ramp_generator_unit: top level of the per-channel twinkle ramp generator
// depends on ltr_pkg, ltr_duty_map, ltr_out_fifo
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel carries one command beat: kind, channel, new_step, new_top,
//   new_bottom and floor_level. A restart beat (kind 1) loads the channel's
//   step, top and bottom, clears its level and sets it rising; it gives no
//   result. An advance beat (kind 0) moves the ramp one step and gives one
//   m_ beat with the channel and its mapped duty. Beats for a channel at or
//   beyond CHANNELS are dropped. Advance a channel only after a restart.
//   With an empty queue m_valid rises once the beat has passed the p1 and
//   p2 registers and has been written into the queue.
//   Throughput is one beat per cycle while s_ready is high; the per-channel
//   state sits in one synchronous RAM that is read at accept and written back
//   in the next cycle, with the written entry forwarded to a following beat
//   on the same channel. Results go through a four-entry queue; s_ready drops
//   only when the queue plus the two pipeline stages would hold four beats,
//   so a stalled receiver backs up the input after at most four in-range advance beats.
//   Reset empties the pipeline and the queue; the RAM is not cleared.
//

module led_twinkle_ramp_generator_unit #(
    parameter int CHANNELS = ltr_pkg::DEFAULT_CHANNELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [ltr_pkg::CHAN_W-1:0]     s_channel,
    input  logic [ltr_pkg::LEVEL_W-1:0]    s_new_step,
    input  logic [ltr_pkg::BRIGHT_W-1:0]   s_new_top,
    input  logic [ltr_pkg::BRIGHT_W-1:0]   s_new_bottom,
    input  logic [ltr_pkg::BRIGHT_W-1:0]   s_floor_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ltr_pkg::CHAN_W-1:0]     m_out_channel,
    output logic [ltr_pkg::BRIGHT_W-1:0]   m_duty_level
);
    import ltr_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = CHAN_W + 3;

    ramp_entry_t         ram [CHANNELS];
    ramp_entry_t         rd_data_reg;

    logic                s_accept;
    logic [EXT_W-1:0]    s_chan_ext;
    logic [ADDR_W-1:0]   rd_addr;

    logic                p1_valid_reg;
    logic                p1_kind_reg;
    logic                p1_in_range_reg;
    logic [ADDR_W-1:0]   p1_addr_reg;
    logic [CHAN_W-1:0]   p1_channel_reg;
    logic [LEVEL_W-1:0]  p1_step_reg;
    logic [BRIGHT_W-1:0] p1_top_reg;
    logic [BRIGHT_W-1:0] p1_bottom_reg;
    logic [BRIGHT_W-1:0] p1_floor_reg;

    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    ramp_entry_t         fwd_entry_reg;

    ramp_entry_t         cur_entry;
    ramp_entry_t         wb_entry;
    logic                wb_en;
    logic [LEVEL_W:0]    up_sum;
    logic [BRIGHT_W-1:0] span_mag;
    map_req_t            map_req_next;
    map_req_t            map_req_reg;
    logic                p2_valid_next;
    logic                p2_valid_reg;

    out_beat_t           map_beat;
    out_beat_t           head_beat;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   occupancy;

    assign s_chan_ext = EXT_W'(s_channel);
    assign rd_addr    = s_chan_ext[ADDR_W-1:0];
    assign s_accept   = s_valid && s_ready;

    always_comb begin
        occupancy = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(p1_valid_reg)
                  + (FIFO_CNT_W+1)'(p2_valid_reg);
        s_ready = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    end

    // state ram, registered read
    always_ff @(posedge aclk) begin
        if (wb_en) begin
            ram[p1_addr_reg] <= wb_entry;
        end
        rd_data_reg <= ram[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            p2_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg  <= s_accept;
            fwd_valid_reg <= wb_en;
            p2_valid_reg  <= p2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_kind_reg     <= s_kind;
        p1_in_range_reg <= (s_chan_ext < EXT_W'(CHANNELS));
        p1_addr_reg     <= rd_addr;
        p1_channel_reg  <= s_channel;
        p1_step_reg     <= s_new_step;
        p1_top_reg      <= s_new_top;
        p1_bottom_reg   <= s_new_bottom;
        p1_floor_reg    <= s_floor_level;
        fwd_addr_reg    <= p1_addr_reg;
        fwd_entry_reg   <= wb_entry;
        map_req_reg     <= map_req_next;
    end

    // read-modify-write of the channel entry
    always_comb begin
        cur_entry = (fwd_valid_reg && (fwd_addr_reg == p1_addr_reg)) ? fwd_entry_reg
                                                                     : rd_data_reg;
        wb_entry  = cur_entry;
        up_sum    = {1'b0, cur_entry.level} + {1'b0, cur_entry.step};
        if (p1_kind_reg == KIND_RESTART) begin
            wb_entry.level  = '0;
            wb_entry.rising = 1'b1;
            wb_entry.step   = p1_step_reg;
            wb_entry.top    = p1_top_reg;
            wb_entry.bottom = p1_bottom_reg;
        end else if (cur_entry.rising) begin
            if (up_sum[LEVEL_W]) begin
                wb_entry.level  = LEVEL_MAX;
                wb_entry.rising = 1'b0;
                wb_entry.step   = p1_step_reg;
                wb_entry.bottom = p1_bottom_reg;
            end else begin
                wb_entry.level = up_sum[LEVEL_W-1:0];
            end
        end else begin
            if (cur_entry.level < cur_entry.step) begin
                wb_entry.level  = '0;
                wb_entry.rising = 1'b1;
                wb_entry.step   = p1_step_reg;
                wb_entry.top    = p1_top_reg;
            end else begin
                wb_entry.level = cur_entry.level - cur_entry.step;
            end
        end

        wb_en         = p1_valid_reg && p1_in_range_reg;
        p2_valid_next = wb_en && (p1_kind_reg == KIND_ADVANCE);

        map_req_next.neg = (wb_entry.top < wb_entry.bottom);
        span_mag = map_req_next.neg ? (wb_entry.bottom - wb_entry.top)
                                    : (wb_entry.top - wb_entry.bottom);
        map_req_next.prod        = PROD_W'(wb_entry.level) * PROD_W'(span_mag);
        map_req_next.bottom      = wb_entry.bottom;
        map_req_next.floor_level = p1_floor_reg;
        map_req_next.channel     = p1_channel_reg;
    end

    ltr_duty_map u_duty_map (
        .req  (map_req_reg),
        .beat (map_beat)
    );

    ltr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p2_valid_reg),
        .push_beat (map_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head_beat (head_beat),
        .count     (fifo_count)
    );

    assign m_out_channel = head_beat.channel;
    assign m_duty_level  = head_beat.duty;

endmodule

// File: hdl/ltr_checker.sv
// ltr_checker: port-level assertions for led_twinkle_ramp_generator_unit
// depends on ltr_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module ltr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_kind,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ltr_pkg::CHAN_W-1:0]   m_out_channel,
    input logic [ltr_pkg::BRIGHT_W-1:0] m_duty_level
);
    import ltr_pkg::*;

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_channel) && $stable(m_duty_level))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input open right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // a fresh result follows an accepted advance beat that passed p1, p2 and the queue
    a_rise_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_kind == KIND_ADVANCE), 3))
        else $error("result without an advance beat");

endmodule

bind led_twinkle_ramp_generator_unit ltr_checker u_ltr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_kind        (s_kind),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_channel (m_out_channel),
    .m_duty_level  (m_duty_level)
);
